/* rtl/core/zero_crossing_distance_init_top_assert.svh */
// ----------------------------------------------------------------------------
// zero crossing distance init assertion macros
// concurrent checks on aclk, masked while aresetn is low
// ----------------------------------------------------------------------------
`ifndef ZERO_CROSSING_DISTANCE_INIT_TOP_ASSERT_SVH
`define ZERO_CROSSING_DISTANCE_INIT_TOP_ASSERT_SVH
`ifndef SYNTH
`define ZCD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define ZCD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ZCD_ASSERT_IMP(lbl, ante, cons, msg)
`define ZCD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/core/zcd_pkg.sv */
// ----------------------------------------------------------------------------
// zcd_pkg
// shared widths, stage indexes and sideband types
// ----------------------------------------------------------------------------
package zcd_pkg;
    localparam int VAL_W      = 16;
    localparam int FRAC_W     = 16;
    localparam int DIST_W     = 16;
    localparam int LANE_STEPS = 16;
    localparam int DIV_STEPS  = 30;
    localparam int SQRT_STEPS = 15;

    // merge stage indexes
    localparam int MRG_MIN    = 0;
    localparam int MRG_SQ     = 1;
    localparam int MRG_PROD   = 2;
    localparam int DIV_FIRST  = 3;
    localparam int DIV_LAST   = DIV_FIRST + DIV_STEPS - 1;
    localparam int SQRT_FIRST = DIV_LAST + 1;
    localparam int SQRT_LAST  = SQRT_FIRST + SQRT_STEPS - 1;

    typedef struct packed {
        logic crossing;
        logic inner;
    } lane_tag_t;
endpackage

/* rtl/core/zero_crossing_distance_init_top.sv */
// ----------------------------------------------------------------------------
// zero_crossing_distance_init_top
// level-set interface distance estimate for one grid point per transaction
// ----------------------------------------------------------------------------
//  channel | ports                               | direction
//  --------+-------------------------------------+----------
//  s_      | s_valid/s_ready, center + 4 nbrs    | in
//  m_      | m_valid/m_ready, crossing/dist      | out
//
//  one transaction accepted per cycle while s_ready is high; the pipeline is
//  17 divider lane stages plus 48 merge stages: 3 setup, 30 divide, 15 root
//  every stage has its own valid bit; a stage loads when empty or draining,
//  so bubbles close up and s_ready drops only when every stage is full
//  and m_ready is low
//  aresetn is synchronous and clears only the valid bits
// ----------------------------------------------------------------------------
module zero_crossing_distance_init_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [zcd_pkg::VAL_W-1:0]   s_center_value,
    input  logic signed [zcd_pkg::VAL_W-1:0]   s_row_minus_value,
    input  logic signed [zcd_pkg::VAL_W-1:0]   s_row_plus_value,
    input  logic signed [zcd_pkg::VAL_W-1:0]   s_col_minus_value,
    input  logic signed [zcd_pkg::VAL_W-1:0]   s_col_plus_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_is_crossing,
    output logic                               m_is_inside,
    output logic [zcd_pkg::DIST_W-1:0]         m_distance,
    output logic signed [zcd_pkg::DIST_W:0]    m_signed_distance
);
    import zcd_pkg::*;

    // lane order: row minus, row plus, col minus, col plus
    localparam int NL = 4;

    logic signed [16:0] c17, oc;
    logic signed [16:0] n17  [NL];
    logic signed [16:0] on17 [NL];
    logic signed [17:0] dd   [NL];
    logic [NL-1:0]      has, zero, pos;
    logic               inner, crossing;
    lane_tag_t          tag;

    logic [NL-1:0]      l_in_ready, l_out_valid, l_has;
    logic [FRAC_W-1:0]  l_q [NL];
    lane_tag_t          l_tag;
    logic               m_in_ready;

    // orient so the center is never negative; inside points flip all signs
    always_comb begin
        c17    = 17'(s_center_value);
        n17[0] = 17'(s_row_minus_value);
        n17[1] = 17'(s_row_plus_value);
        n17[2] = 17'(s_col_minus_value);
        n17[3] = 17'(s_col_plus_value);
        inner  = (c17 <= 0);
        oc     = inner ? -c17 : c17;
        for (int i = 0; i < NL; i++) begin
            pos[i]  = (n17[i] > 0);
            on17[i] = inner ? -n17[i] : n17[i];
            has[i]  = (on17[i] <= 0);
            dd[i]   = 18'(oc) - 18'(on17[i]);
            zero[i] = (dd[i] == 0);
        end
        // a zero neighbour alone never makes an inside crossing
        crossing     = inner ? (|pos) : (|(~pos));
        tag.crossing = crossing;
        tag.inner    = inner;
    end

    assign s_ready = &l_in_ready;

    for (genvar i = 0; i < NL; i++) begin : g_lane
        zcd_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (s_valid),
            .in_ready  (l_in_ready[i]),
            .in_c      (oc[16:0]),
            .in_d      (dd[i][16:0]),
            .in_has    (has[i]),
            .in_zero   (zero[i]),
            .in_tag    (tag),
            .out_valid (l_out_valid[i]),
            .out_ready (m_in_ready),
            .out_q     (l_q[i]),
            .out_has   (l_has[i]),
            .out_tag   ()
        );
    end

    // lanes run in lockstep; the sideband tag is taken from one copy
    zcd_lane u_tag_lane (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid && s_ready),
        .in_ready  (),
        .in_c      (oc[16:0]),
        .in_d      (dd[0][16:0]),
        .in_has    (has[0]),
        .in_zero   (zero[0]),
        .in_tag    (tag),
        .out_valid (),
        .out_ready (m_in_ready),
        .out_q     (),
        .out_has   (),
        .out_tag   (l_tag)
    );

    zcd_merge u_merge (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .in_valid            (&l_out_valid),
        .in_ready            (m_in_ready),
        .q_rm                (l_q[0]),
        .q_rp                (l_q[1]),
        .q_cm                (l_q[2]),
        .q_cp                (l_q[3]),
        .has_rm              (l_has[0]),
        .has_rp              (l_has[1]),
        .has_cm              (l_has[2]),
        .has_cp              (l_has[3]),
        .in_tag              (l_tag),
        .out_valid           (m_valid),
        .out_ready           (m_ready),
        .out_is_crossing     (m_is_crossing),
        .out_is_inside       (m_is_inside),
        .out_distance        (m_distance),
        .out_signed_distance (m_signed_distance)
    );

`include "zero_crossing_distance_init_top_assert.svh"

    // no crossing means no distance
    `ZCD_ASSERT_IMP(a_no_cross_zero, m_valid && !m_is_crossing, m_distance == '0, "no crossing")
    // outside results keep the sign of the distance
    `ZCD_ASSERT_IMP(a_out_sign, m_valid && !m_is_inside, m_signed_distance == m_distance, "sign")
    // a fraction never exceeds one
    `ZCD_ASSERT_IMP(a_dist_max, m_valid, m_distance <= 16'h8000, "distance above one")
    // input side only stalls behind a full pipeline
    `ZCD_ASSERT_IMP(a_stall_full, !s_ready, m_valid && !m_ready, "input stalled with room left")
endmodule

/* rtl/core/zcd_lane.sv */
// ----------------------------------------------------------------------------
// zcd_lane
// pipelined restoring divider, one quotient bit per stage: c*2^15/d
// ----------------------------------------------------------------------------
module zcd_lane (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [16:0]              in_c,
    input  logic [16:0]              in_d,
    input  logic                     in_has,
    input  logic                     in_zero,
    input  zcd_pkg::lane_tag_t       in_tag,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [zcd_pkg::FRAC_W-1:0] out_q,
    output logic                     out_has,
    output zcd_pkg::lane_tag_t       out_tag
);
    import zcd_pkg::*;

    localparam int NS = LANE_STEPS + 1;

    logic [NS-1:0]     v_reg;
    logic [NS:0]       rdy;
    logic [16:0]       r_reg    [NS];
    logic [15:0]       lo_reg   [NS];
    logic [FRAC_W-1:0] q_reg    [NS];
    logic [16:0]       d_reg    [NS];
    logic [NS-1:0]     has_reg;
    logic [NS-1:0]     zero_reg;
    lane_tag_t         tag_reg  [NS];
    logic [16:0]       r_next   [NS];
    logic [15:0]       lo_next  [NS];
    logic [FRAC_W-1:0] q_next   [NS];

    // stall chain, a stage takes data when it is empty or drains
    always_comb begin
        rdy[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    always_comb begin
        logic [17:0] rt;
        logic [17:0] rs;
        r_next[0]  = {1'b0, in_c[16:1]};
        lo_next[0] = {in_c[0], 15'd0};
        q_next[0]  = '0;
        for (int k = 1; k < NS; k++) begin
            rt = {r_reg[k-1], lo_reg[k-1][15]};
            rs = rt - {1'b0, d_reg[k-1]};
            if (rt >= {1'b0, d_reg[k-1]}) begin
                r_next[k] = rs[16:0];
                q_next[k] = {q_reg[k-1][FRAC_W-2:0], 1'b1};
            end else begin
                r_next[k] = rt[16:0];
                q_next[k] = {q_reg[k-1][FRAC_W-2:0], 1'b0};
            end
            lo_next[k] = {lo_reg[k-1][14:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            r_reg[0]    <= r_next[0];
            lo_reg[0]   <= lo_next[0];
            q_reg[0]    <= q_next[0];
            d_reg[0]    <= in_d;
            has_reg[0]  <= in_has;
            zero_reg[0] <= in_zero;
            tag_reg[0]  <= in_tag;
        end
        for (int k = 1; k < NS; k++) begin
            if (rdy[k]) begin
                r_reg[k]    <= r_next[k];
                lo_reg[k]   <= lo_next[k];
                q_reg[k]    <= q_next[k];
                d_reg[k]    <= d_reg[k-1];
                has_reg[k]  <= has_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                tag_reg[k]  <= tag_reg[k-1];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NS-1];
    // zero over zero repaired to zero
    assign out_q     = zero_reg[NS-1] ? '0 : q_reg[NS-1];
    assign out_has   = has_reg[NS-1];
    assign out_tag   = tag_reg[NS-1];
endmodule

/* rtl/core/zcd_merge.sv */
// ----------------------------------------------------------------------------
// zcd_merge
// per-axis minimum, then s*t/sqrt(s^2+t^2) by pipelined divide and root
// ----------------------------------------------------------------------------
module zcd_merge (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [zcd_pkg::FRAC_W-1:0] q_rm,
    input  logic [zcd_pkg::FRAC_W-1:0] q_rp,
    input  logic [zcd_pkg::FRAC_W-1:0] q_cm,
    input  logic [zcd_pkg::FRAC_W-1:0] q_cp,
    input  logic                       has_rm,
    input  logic                       has_rp,
    input  logic                       has_cm,
    input  logic                       has_cp,
    input  zcd_pkg::lane_tag_t         in_tag,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       out_is_crossing,
    output logic                       out_is_inside,
    output logic [zcd_pkg::DIST_W-1:0] out_distance,
    output logic signed [zcd_pkg::DIST_W:0] out_signed_distance
);
    import zcd_pkg::*;

    localparam int NS = SQRT_LAST + 1;

    logic [NS-1:0]     v_reg;
    logic [NS:0]       rdy;
    lane_tag_t         tag_reg    [NS];
    logic [NS-1:0]     both_reg;
    logic [DIST_W-1:0] direct_reg [NS];

    logic [FRAC_W-1:0] s_reg, t_reg;
    logic [30:0]       s2_reg, t2_reg;

    logic [31:0]          dr_reg   [MRG_PROD:DIV_LAST];
    logic [DIV_STEPS-1:0] dlo_reg  [MRG_PROD:DIV_LAST];
    logic [DIV_STEPS-1:0] dq_reg   [MRG_PROD:DIV_LAST];
    logic [31:0]          den_reg  [MRG_PROD:DIV_LAST];
    logic                 dz_reg   [MRG_PROD:DIV_LAST];
    logic [31:0]          dr_next  [MRG_PROD:DIV_LAST];
    logic [DIV_STEPS-1:0] dlo_next [MRG_PROD:DIV_LAST];
    logic [DIV_STEPS-1:0] dq_next  [MRG_PROD:DIV_LAST];
    logic [31:0]          den_next;

    logic [16:0]          rem_reg  [SQRT_FIRST:SQRT_LAST];
    logic [14:0]          root_reg [SQRT_FIRST:SQRT_LAST];
    logic [DIV_STEPS-1:0] x_reg    [SQRT_FIRST:SQRT_LAST];
    logic [16:0]          rem_next [SQRT_FIRST:SQRT_LAST];
    logic [14:0]          root_next[SQRT_FIRST:SQRT_LAST];
    logic [DIV_STEPS-1:0] x_next   [SQRT_FIRST:SQRT_LAST];

    logic [FRAC_W-1:0] s_next, t_next, direct_next;
    logic              hs, ht;
    logic [61:0]       prod;
    logic [DIST_W-1:0] dist_sel;

    always_comb begin
        rdy[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    // smallest fraction on each axis
    always_comb begin
        hs = has_cm || has_cp;
        ht = has_rm || has_rp;
        if (has_cm && has_cp) begin
            s_next = (q_cp < q_cm) ? q_cp : q_cm;
        end else begin
            s_next = has_cm ? q_cm : q_cp;
        end
        if (has_rm && has_rp) begin
            t_next = (q_rp < q_rm) ? q_rp : q_rm;
        end else begin
            t_next = has_rm ? q_rm : q_rp;
        end
        direct_next = hs ? s_next : t_next;
    end

    assign prod     = {31'd0, s2_reg} * {31'd0, t2_reg};
    assign den_next = {1'b0, s2_reg} + {1'b0, t2_reg};

    always_comb begin
        logic [32:0] dt;
        logic [32:0] ds;
        dr_next[MRG_PROD]  = {1'b0, prod[60:30]};
        dlo_next[MRG_PROD] = prod[29:0];
        dq_next[MRG_PROD]  = '0;
        for (int k = DIV_FIRST; k <= DIV_LAST; k++) begin
            dt = {dr_reg[k-1], dlo_reg[k-1][DIV_STEPS-1]};
            ds = dt - {1'b0, den_reg[k-1]};
            if (dt >= {1'b0, den_reg[k-1]}) begin
                dr_next[k] = ds[31:0];
                dq_next[k] = {dq_reg[k-1][DIV_STEPS-2:0], 1'b1};
            end else begin
                dr_next[k] = dt[31:0];
                dq_next[k] = {dq_reg[k-1][DIV_STEPS-2:0], 1'b0};
            end
            dlo_next[k] = {dlo_reg[k-1][DIV_STEPS-2:0], 1'b0};
        end
    end

    // digit-by-digit square root, two radicand bits per stage
    always_comb begin
        logic [16:0]          rem_p;
        logic [14:0]          root_p;
        logic [DIV_STEPS-1:0] x_p;
        logic [18:0]          rem2;
        logic [18:0]          trial;
        logic [18:0]          sub;
        for (int k = SQRT_FIRST; k <= SQRT_LAST; k++) begin
            if (k == SQRT_FIRST) begin
                rem_p  = '0;
                root_p = '0;
                x_p    = dz_reg[DIV_LAST] ? '0 : dq_reg[DIV_LAST];
            end else begin
                rem_p  = rem_reg[k-1];
                root_p = root_reg[k-1];
                x_p    = x_reg[k-1];
            end
            rem2  = {rem_p, x_p[DIV_STEPS-1:DIV_STEPS-2]};
            trial = {2'b00, root_p, 2'b01};
            sub   = rem2 - trial;
            if (rem2 >= trial) begin
                rem_next[k]  = sub[16:0];
                root_next[k] = {root_p[13:0], 1'b1};
            end else begin
                rem_next[k]  = rem2[16:0];
                root_next[k] = {root_p[13:0], 1'b0};
            end
            x_next[k] = {x_p[DIV_STEPS-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[MRG_MIN]) begin
            tag_reg[MRG_MIN]    <= in_tag;
            both_reg[MRG_MIN]   <= hs && ht;
            direct_reg[MRG_MIN] <= direct_next;
            s_reg               <= s_next;
            t_reg               <= t_next;
        end
        for (int k = 1; k < NS; k++) begin
            if (rdy[k]) begin
                tag_reg[k]    <= tag_reg[k-1];
                both_reg[k]   <= both_reg[k-1];
                direct_reg[k] <= direct_reg[k-1];
            end
        end
        if (rdy[MRG_SQ]) begin
            s2_reg <= 31'({16'd0, s_reg} * {16'd0, s_reg});
            t2_reg <= 31'({16'd0, t_reg} * {16'd0, t_reg});
        end
        if (rdy[MRG_PROD]) begin
            dr_reg[MRG_PROD]  <= dr_next[MRG_PROD];
            dlo_reg[MRG_PROD] <= dlo_next[MRG_PROD];
            dq_reg[MRG_PROD]  <= dq_next[MRG_PROD];
            den_reg[MRG_PROD] <= den_next;
            dz_reg[MRG_PROD]  <= (den_next == '0);
        end
        for (int k = DIV_FIRST; k <= DIV_LAST; k++) begin
            if (rdy[k]) begin
                dr_reg[k]  <= dr_next[k];
                dlo_reg[k] <= dlo_next[k];
                dq_reg[k]  <= dq_next[k];
                den_reg[k] <= den_reg[k-1];
                dz_reg[k]  <= dz_reg[k-1];
            end
        end
        for (int k = SQRT_FIRST; k <= SQRT_LAST; k++) begin
            if (rdy[k]) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                x_reg[k]    <= x_next[k];
            end
        end
    end

    always_comb begin
        if (!tag_reg[NS-1].crossing) begin
            dist_sel = '0;
        end else if (both_reg[NS-1]) begin
            dist_sel = {1'b0, root_reg[SQRT_LAST]};
        end else begin
            dist_sel = direct_reg[NS-1];
        end
    end

    assign in_ready            = rdy[0];
    assign out_valid           = v_reg[NS-1];
    assign out_is_crossing     = tag_reg[NS-1].crossing;
    assign out_is_inside       = tag_reg[NS-1].inner;
    assign out_distance        = dist_sel;
    assign out_signed_distance = tag_reg[NS-1].inner ? -$signed({1'b0, dist_sel})
                                                     : $signed({1'b0, dist_sel});
endmodule

/* sim/zero_crossing_distance_init_top_test.sv */
// ----------------------------------------------------------------------------
// zero_crossing_distance_init_top_test
// streams grid points through the distance initializer and checks every
// result transaction against an in-bench bit-exact estimate of the distance
// ----------------------------------------------------------------------------
module zero_crossing_distance_init_top_test;
    import zcd_pkg::*;

    typedef struct packed {
        logic signed [VAL_W-1:0] center;
        logic signed [VAL_W-1:0] row_m;
        logic signed [VAL_W-1:0] row_p;
        logic signed [VAL_W-1:0] col_m;
        logic signed [VAL_W-1:0] col_p;
    } point_t;

    typedef struct packed {
        logic              crossing;
        logic              inner;
        logic [DIST_W-1:0] distance;
        logic [DIST_W:0]   sdist;
    } estimate_t;

    localparam int CYCLE_LIMIT = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [VAL_W-1:0] s_center_value = '0;
    logic signed [VAL_W-1:0] s_row_minus_value = '0;
    logic signed [VAL_W-1:0] s_row_plus_value = '0;
    logic signed [VAL_W-1:0] s_col_minus_value = '0;
    logic signed [VAL_W-1:0] s_col_plus_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_is_crossing;
    logic m_is_inside;
    logic [DIST_W-1:0] m_distance;
    logic signed [DIST_W:0] m_signed_distance;

    point_t    pending_points[$];
    estimate_t expected_estimates[$];
    int        error_count = 0;
    int        cycle_count = 0;
    int        sent_count = 0;
    int        checked_count = 0;
    int        crossing_count = 0;
    bit        stimulus_done = 1'b0;
    bit        calm_stretch = 1'b0;
    // an input transaction completed at the last rising edge
    bit        s_ready_seen = 1'b0;

    zero_crossing_distance_init_top i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_center_value    (s_center_value),
        .s_row_minus_value (s_row_minus_value),
        .s_row_plus_value  (s_row_plus_value),
        .s_col_minus_value (s_col_minus_value),
        .s_col_plus_value  (s_col_plus_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_is_crossing     (m_is_crossing),
        .m_is_inside       (m_is_inside),
        .m_distance        (m_distance),
        .m_signed_distance (m_signed_distance)
    );

    always #1 aclk = ~aclk;

    // bitwise integer square root, floor
    function automatic longint unsigned root_floor(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // q1.15 crossing fraction c/(c-n); zero over zero gives 0
    function automatic longint unsigned crossing_fraction(input longint c, input longint n);
        if (c - n == 0) return 0;
        return (c <<< 15) / (c - n);
    endfunction

    // nearest crossing along one axis; returns whether the axis has one
    function automatic bit axis_nearest(input longint c, input longint a, input longint b,
                                        output longint unsigned frac);
        bit have;
        longint unsigned f;
        have = 1'b0;
        frac = 0;
        if (a <= 0) begin
            frac = crossing_fraction(c, a);
            have = 1'b1;
        end
        if (b <= 0) begin
            f = crossing_fraction(c, b);
            if (!have || f < frac) frac = f;
            have = 1'b1;
        end
        return have;
    endfunction

    function automatic estimate_t interface_distance(input point_t p);
        estimate_t e;
        longint c, rm, rp, cm, cp;
        longint unsigned s, t, s2, t2, d;
        bit hs, ht;
        c = p.center; rm = p.row_m; rp = p.row_p; cm = p.col_m; cp = p.col_p;
        d = 0;
        e.inner = (c <= 0);
        if (!e.inner) e.crossing = (rm <= 0 || rp <= 0 || cm <= 0 || cp <= 0);
        else          e.crossing = (rm > 0 || rp > 0 || cm > 0 || cp > 0);
        if (e.crossing) begin
            // inside points are mirrored so the center is non-negative
            if (e.inner) begin
                c = -c; rm = -rm; rp = -rp; cm = -cm; cp = -cp;
            end
            hs = axis_nearest(c, cm, cp, s);
            ht = axis_nearest(c, rm, rp, t);
            if (hs && ht) begin
                s2 = s * s;
                t2 = t * t;
                d = (s2 + t2 == 0) ? 0 : root_floor((s2 * t2) / (s2 + t2));
            end else if (hs) begin
                d = s;
            end else begin
                d = t;
            end
        end
        e.distance = d[DIST_W-1:0];
        e.sdist = e.inner ? (17'(0) - 17'(d)) : 17'(d);
        return e;
    endfunction

    function automatic logic [VAL_W-1:0] any_value();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_point(input int c, input int rm, input int rp, input int cm,
                               input int cp);
        point_t p;
        p.center = 16'(c); p.row_m = 16'(rm); p.row_p = 16'(rp);
        p.col_m = 16'(cm); p.col_p = 16'(cp);
        pending_points.push_back(p);
    endtask

    // points near the interface: neighbours of both signs, random magnitudes
    task automatic queue_random_point();
        point_t p;
        p.center = any_value();
        p.row_m = any_value();
        p.row_p = any_value();
        p.col_m = any_value();
        p.col_p = any_value();
        if ($urandom_range(0, 9) < 7) begin
            // force a sign change against a random neighbour
            case ($urandom_range(0, 3))
                0: p.row_m = -p.center;
                1: p.row_p = -p.center;
                2: p.col_m = -p.center;
                default: p.col_p = -p.center;
            endcase
        end
        pending_points.push_back(p);
    endtask

    initial begin
        // directed: extremes, both axes, one axis, zero over zero, zero neighbours
        queue_point(0, 0, 0, 0, 0);
        queue_point(0, 0, 0, 0, 1);
        queue_point(0, 1, 0, 0, 0);
        queue_point(0, 0, 5, -5, 7);
        queue_point(256, 256, 256, 256, 256);
        queue_point(-256, -256, -256, -256, -256);
        queue_point(256, -256, 512, 512, 512);
        queue_point(256, 512, 512, -256, 512);
        queue_point(256, -256, 512, -256, 512);
        queue_point(256, 0, 0, 0, 0);
        queue_point(1, 0, 300, 300, 300);
        queue_point(-32768, 32767, 32767, 32767, 32767);
        queue_point(-32768, 1, -32768, -32768, -32768);
        queue_point(32767, -32768, -32768, -32768, -32768);
        queue_point(32767, -1, 100, -1, 100);
        queue_point(1, -32768, -32768, -32768, -32768);
        queue_point(-1, 32767, 0, 0, 32767);
        queue_point(-32768, 32767, 0, 0, 0);
        queue_point(-100, 300, 50, 0, -20);
        queue_point(128, -128, 100, 200, -64);
        queue_point(-5, 5, 5, 5, 5);
        queue_point(32767, 32767, 32767, 32767, 32767);
        repeat (1030) queue_random_point();
    end

    // reset: held low from the start, released on a falling edge
    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // idling goes quiet for a stretch in the middle of the run
    always @(negedge aclk) begin
        calm_stretch <= (cycle_count > 600 && cycle_count < 1100);
    end

    // input driver: one transaction per handshake, payload held while waiting
    always @(negedge aclk) begin
        point_t p;
        if (aresetn) begin
            if (!s_valid || s_ready_seen) begin
                if (pending_points.size() != 0 &&
                    (calm_stretch || $urandom_range(0, 99) >= 6)) begin
                    p = pending_points.pop_front();
                    s_center_value    <= p.center;
                    s_row_minus_value <= p.row_m;
                    s_row_plus_value  <= p.row_p;
                    s_col_minus_value <= p.col_m;
                    s_col_plus_value  <= p.col_p;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                    if (pending_points.size() == 0) stimulus_done <= 1'b1;
                end
            end
            m_ready <= calm_stretch || $urandom_range(0, 99) >= 6;
        end
    end

    always @(posedge aclk) begin
        point_t p;
        s_ready_seen <= 1'b0;
        if (aresetn && s_valid && s_ready) begin
            s_ready_seen <= 1'b1;
            p.center = s_center_value; p.row_m = s_row_minus_value;
            p.row_p = s_row_plus_value; p.col_m = s_col_minus_value;
            p.col_p = s_col_plus_value;
            expected_estimates.push_back(interface_distance(p));
            sent_count++;
        end
    end

    // result monitor: compare each output transaction with the oldest estimate
    always @(posedge aclk) begin
        estimate_t e;
        cycle_count++;
        if (aresetn && m_valid && m_ready) begin
            if (expected_estimates.size() == 0) begin
                $display("%0t: unexpected result crossing=%0b dist=%0d", $time,
                         m_is_crossing, m_distance);
                error_count++;
            end else begin
                e = expected_estimates.pop_front();
                checked_count++;
                if (m_is_crossing) crossing_count++;
                if (m_is_crossing !== e.crossing) begin
                    $display("%0t: is_crossing expected %0b actual %0b", $time, e.crossing,
                             m_is_crossing);
                    error_count++;
                end
                if (m_is_inside !== e.inner) begin
                    $display("%0t: is_inside expected %0b actual %0b", $time, e.inner,
                             m_is_inside);
                    error_count++;
                end
                if (m_distance !== e.distance) begin
                    $display("%0t: distance expected %0d actual %0d", $time, e.distance,
                             m_distance);
                    error_count++;
                end
                if (m_signed_distance !== e.sdist) begin
                    $display("%0t: signed_distance expected %h actual %h", $time, e.sdist,
                             m_signed_distance);
                    error_count++;
                end
            end
        end
    end

    // end of run: drain, let the 65-stage pipeline settle, then report
    initial begin
        wait (stimulus_done && !s_valid && expected_estimates.size() == 0);
        repeat (100) @(posedge aclk);
        $display("covered %0d points, %0d results checked, %0d on the interface",
                 sent_count, checked_count, crossing_count);
        if (error_count == 0 && expected_estimates.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("DONE: errors detected");
        $finish;
    end
endmodule
